[rtl/core/dual_stack_shared_memory_defines.svh]
// ----------------------------------------------------------------------------
// Dual stack shared memory assertion macros
// Shared assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef DUAL_STACK_SHARED_MEMORY_DEFINES_SVH
`define DUAL_STACK_SHARED_MEMORY_DEFINES_SVH

// The implication holds at every clock edge outside reset.
`define DSSM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// The implication is checked in the cycle after the antecedent.
`define DSSM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/dssm_pkg.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory package
// Sizes, request and status codes, and controller command type.
// ----------------------------------------------------------------------------
package dssm_pkg;

  localparam int unsigned Depth     = 16;
  localparam int unsigned AddrW     = $clog2(Depth);
  localparam int unsigned CntW      = $clog2(Depth + 1);
  localparam int unsigned DataW     = 32;
  localparam int unsigned CapW      = 5;
  localparam int unsigned PaddrW    = 3;
  localparam int unsigned PdataW    = 32;

  localparam logic [1:0] OpPush     = 2'd0;
  localparam logic [1:0] OpPop      = 2'd1;
  localparam logic [1:0] OpRead     = 2'd2;

  localparam logic       SelLower   = 1'b0;
  localparam logic       SelUpper   = 1'b1;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StOverflow = 2'd1;
  localparam logic [1:0] StEmpty    = 2'd2;

  localparam logic       RegCapacity = 1'b0;
  localparam logic [CapW-1:0] CapReset = CapW'(16);

  typedef struct packed {
    logic accept;
    logic load;
  } cmd_t;

endpackage

[rtl/core/dssm_req_if.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory request channel
// Valid/ready channel carrying one stack request per beat.
// ----------------------------------------------------------------------------
interface dssm_req_if;
  logic                    valid;
  logic                    ready;
  logic [1:0]              opcode;
  logic                    stack_select;
  logic signed [31:0]      push_value;

  modport source (output valid, output opcode, output stack_select, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_select, input push_value,
                  output ready);
endinterface

[rtl/core/dssm_rsp_if.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory response channel
// Valid/ready channel carrying one result per beat.
// ----------------------------------------------------------------------------
interface dssm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] top_value;
  logic [1:0]         status;
  logic               lower_empty;
  logic               upper_empty;
  logic               store_full;

  modport source (output valid, output top_value, output status, output lower_empty,
                  output upper_empty, output store_full, input ready);
  modport sink   (input valid, input top_value, input status, input lower_empty,
                  input upper_empty, input store_full, output ready);
endinterface

[rtl/core/dssm_ctrl.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory controller
// Sequences one request through execute and result load stages.
// ----------------------------------------------------------------------------
module dssm_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output dssm_pkg::cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   load;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign load        = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);
  assign cmd_o.accept = in_valid_i && in_ready_o;
  assign cmd_o.load   = load;
  assign out_valid_o  = out_valid_q;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.accept) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/dssm_datapath.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory datapath
// Stack counters, capacity register, shared memory and result register.
// ----------------------------------------------------------------------------
module dssm_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dssm_pkg::cmd_t                  cmd_i,
  input  logic [1:0]                      opcode_i,
  input  logic                            stack_select_i,
  input  logic signed [dssm_pkg::DataW-1:0] push_value_i,
  input  logic                            cfg_we_i,
  input  logic [dssm_pkg::CapW-1:0]       cfg_wdata_i,
  output logic [dssm_pkg::CapW-1:0]       capacity_o,
  output logic signed [dssm_pkg::DataW-1:0] top_value_o,
  output logic [1:0]                      status_o,
  output logic                            lower_empty_o,
  output logic                            upper_empty_o,
  output logic                            store_full_o
);

  localparam int unsigned SumW = dssm_pkg::CntW + 1;

  logic [dssm_pkg::CapW-1:0]  capacity_q;
  logic [dssm_pkg::CntW-1:0]  lower_q, lower_d;
  logic [dssm_pkg::CntW-1:0]  upper_q, upper_d;
  logic [dssm_pkg::DataW-1:0] mem_q [dssm_pkg::Depth];
  logic [dssm_pkg::DataW-1:0] rd_q;
  logic                       rd_ok_q, rd_ok_d;
  logic [1:0]                 res_status_q, res_status_d;
  logic [dssm_pkg::CntW-1:0]  cap;
  logic [SumW-1:0]            used;
  logic                       full;
  logic                       wr_en;
  logic [dssm_pkg::CntW-1:0]  wr_idx;
  logic [dssm_pkg::CntW-1:0]  rd_idx;
  logic [dssm_pkg::DataW-1:0] top_q;
  logic [1:0]                 status_q;
  logic                       lower_empty_q, upper_empty_q, full_q;

  always_comb begin
    if (capacity_q == '0) begin
      cap = dssm_pkg::CntW'(1);
    end else if (SumW'(capacity_q) > SumW'(dssm_pkg::Depth)) begin
      cap = dssm_pkg::CntW'(dssm_pkg::Depth);
    end else begin
      cap = dssm_pkg::CntW'(capacity_q);
    end
  end

  assign used = SumW'(lower_q) + SumW'(upper_q);
  assign full = used >= SumW'(cap);

  always_comb begin
    lower_d      = lower_q;
    upper_d      = upper_q;
    rd_ok_d      = 1'b0;
    res_status_d = dssm_pkg::StDone;
    wr_en        = 1'b0;
    wr_idx       = lower_q;
    rd_idx       = lower_q - dssm_pkg::CntW'(1);
    if (stack_select_i == dssm_pkg::SelUpper) begin
      wr_idx = cap - upper_q - dssm_pkg::CntW'(1);
      rd_idx = cap - upper_q;
    end
    case (opcode_i)
      dssm_pkg::OpPush: begin
        if (full) begin
          res_status_d = dssm_pkg::StOverflow;
        end else if (stack_select_i == dssm_pkg::SelLower) begin
          wr_en   = 1'b1;
          lower_d = lower_q + dssm_pkg::CntW'(1);
        end else begin
          wr_en   = 1'b1;
          upper_d = upper_q + dssm_pkg::CntW'(1);
        end
      end
      dssm_pkg::OpPop: begin
        if (stack_select_i == dssm_pkg::SelLower) begin
          if (lower_q == '0) begin
            res_status_d = dssm_pkg::StEmpty;
          end else begin
            lower_d = lower_q - dssm_pkg::CntW'(1);
          end
        end else begin
          if (upper_q == '0) begin
            res_status_d = dssm_pkg::StEmpty;
          end else begin
            upper_d = upper_q - dssm_pkg::CntW'(1);
          end
        end
      end
      dssm_pkg::OpRead: begin
        if (((stack_select_i == dssm_pkg::SelLower) && (lower_q == '0)) ||
            ((stack_select_i == dssm_pkg::SelUpper) && (upper_q == '0))) begin
          res_status_d = dssm_pkg::StEmpty;
        end else begin
          rd_ok_d = 1'b1;
        end
      end
      default: begin
        res_status_d = dssm_pkg::StDone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= dssm_pkg::CapReset;
      lower_q    <= '0;
      upper_q    <= '0;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
      lower_q    <= '0;
      upper_q    <= '0;
    end else if (cmd_i.accept) begin
      lower_q    <= lower_d;
      upper_q    <= upper_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && wr_en) begin
      mem_q[wr_idx[dssm_pkg::AddrW-1:0]] <= push_value_i;
    end
    if (cmd_i.accept) begin
      rd_q         <= mem_q[rd_idx[dssm_pkg::AddrW-1:0]];
      rd_ok_q      <= rd_ok_d;
      res_status_q <= res_status_d;
    end
    if (cmd_i.load) begin
      top_q         <= rd_ok_q ? rd_q : '1;
      status_q      <= res_status_q;
      lower_empty_q <= (lower_q == '0);
      upper_empty_q <= (upper_q == '0);
      full_q        <= full;
    end
  end

  assign capacity_o    = capacity_q;
  assign top_value_o   = top_q;
  assign status_o      = status_q;
  assign lower_empty_o = lower_empty_q;
  assign upper_empty_o = upper_empty_q;
  assign store_full_o  = full_q;

endmodule

[rtl/core/dual_stack_shared_memory.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory
// Two stacks sharing one memory, growing toward each other.
// ----------------------------------------------------------------------------
// A request beat on req_i carries an opcode (push, pop, read top), a stack
// select and a push value. Every request returns exactly one response beat on
// rsp_o with a status code, the two empty flags and the full flag as they stand
// after the request, and the top value, which is all ones unless a read succeeds.
// The edge that accepts a request updates the counters, writes the memory and
// registers the memory read; in the finish state the controller then loads the
// output register, which makes the response valid. The controller takes no new
// request until the result of the last one is loaded into the output register.
// If the receiver stalls, the finished result waits in the datapath's staging
// registers until the output register is free, and no new request is taken
// meanwhile.
// Reset empties both stacks and sets the capacity register to sixteen; memory
// contents are not cleared. The capacity register sits at APB addresses 0-3, and
// writing it empties both stacks. Write it only while no request is in flight.
// ----------------------------------------------------------------------------
module dual_stack_shared_memory (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dssm_req_if.sink                      req_i,
  dssm_rsp_if.source                    rsp_o,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [dssm_pkg::PaddrW-1:0]   paddr_i,
  input  logic [dssm_pkg::PdataW-1:0]   pwdata_i,
  output logic [dssm_pkg::PdataW-1:0]   prdata_o,
  output logic                          pready_o
);

  dssm_pkg::cmd_t              cmd;
  logic                        cfg_we;
  logic                        reg_hit;
  logic [dssm_pkg::CapW-1:0]   capacity;

  assign pready_o = 1'b1;
  assign reg_hit  = (paddr_i[dssm_pkg::PaddrW-1] == dssm_pkg::RegCapacity);
  assign cfg_we   = psel_i && penable_i && pwrite_i && pready_o && reg_hit;
  assign prdata_o = reg_hit ? dssm_pkg::PdataW'(capacity) : '0;

  dssm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (cmd)
  );

  dssm_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .opcode_i       (req_i.opcode),
    .stack_select_i (req_i.stack_select),
    .push_value_i   (req_i.push_value),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata_i[dssm_pkg::CapW-1:0]),
    .capacity_o     (capacity),
    .top_value_o    (rsp_o.top_value),
    .status_o       (rsp_o.status),
    .lower_empty_o  (rsp_o.lower_empty),
    .upper_empty_o  (rsp_o.upper_empty),
    .store_full_o   (rsp_o.store_full)
  );

endmodule

[rtl/core/dssm_checker.sv]
// ----------------------------------------------------------------------------
// Dual stack shared memory port checker
// Port-level properties of the request and response channels.
// ----------------------------------------------------------------------------
`include "dual_stack_shared_memory_defines.svh"

module dssm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] top_value_i,
  input logic [1:0]  status_i,
  input logic        lower_empty_i,
  input logic        upper_empty_i,
  input logic        store_full_i
);

  `DSSM_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(top_value_i))
  `DSSM_ASSERT_IMPL(a_status_code, out_valid_i, status_i <= dssm_pkg::StEmpty)
  `DSSM_ASSERT_IMPL(a_fail_top, out_valid_i && status_i != dssm_pkg::StDone, top_value_i == '1)
  `DSSM_ASSERT_IMPL(a_full_nonempty, out_valid_i && store_full_i, !(lower_empty_i && upper_empty_i))
  `DSSM_ASSERT_NEXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)

endmodule

bind dual_stack_shared_memory dssm_checker u_dssm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (req_i.valid),
  .in_ready_i    (req_i.ready),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .top_value_i   (rsp_o.top_value),
  .status_i      (rsp_o.status),
  .lower_empty_i (rsp_o.lower_empty),
  .upper_empty_i (rsp_o.upper_empty),
  .store_full_i  (rsp_o.store_full)
);
